/* rtl/core/line_rasterizer_top_assert.svh */
// Assertion helpers for the line rasterizer.
`ifndef LINE_RASTERIZER_TOP_ASSERT_SVH
`define LINE_RASTERIZER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define LR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lr_pkg.sv */
package lr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_POINTS = 64;

    localparam int COORD_W    = 12;
    localparam int DIM_W      = 11;
    localparam int ADDR_W     = 20;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int ERR_W      = COORD_W + 3;
    localparam int CNT_W      = $clog2(MAX_POINTS);

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DRAW_COLOR    = CFG_IDX_W'(2);

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'((1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_RESET =
        DIM_W'((1024 < MAX_HEIGHT) ? 1024 : MAX_HEIGHT);

    typedef enum logic [1:0] {
        LR_IDLE,
        LR_SETUP,
        LR_WALK
    } lr_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } lr_seg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      trunc;
    } lr_point_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int lim);
        logic [DIM_W-1:0] r;
        if (int'(v) < lim)
        begin
            r = v;
        end
        else
        begin
            r = DIM_W'(lim);
        end
        return r;
    endfunction

endpackage

/* rtl/core/lr_if.sv */
interface lr_seg_if import lr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lr_pt_if import lr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [ADDR_W-1:0]         write_address;
    logic                      write_enable;
    logic [COLOR_W-1:0]        pixel_color;
    logic                      last_point;
    logic                      truncated;

    modport source (output valid, point_x, point_y, write_address, write_enable,
                    pixel_color, last_point, truncated, input ready);
    modport sink (input valid, point_x, point_y, write_address, write_enable,
                  pixel_color, last_point, truncated, output ready);
endinterface

interface lr_cfg_if import lr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/lr_walk.sv */
module lr_walk import lr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  lr_seg_t   seg_in,
    input  logic      advance,
    output logic      idle,
    output logic      point_valid,
    output lr_point_t point
);

    lr_state_t                 state_reg, state_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] y_reg, y_next;
    logic signed [COORD_W-1:0] xe_reg, xe_next;
    logic signed [COORD_W-1:0] ye_reg, ye_next;
    logic [DELTA_W-1:0]        dx_reg, dx_next;
    logic [DELTA_W-1:0]        dy_reg, dy_next;
    logic                      sx_neg_reg, sx_neg_next;
    logic                      sy_neg_reg, sy_neg_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    logic signed [DELTA_W-1:0] diff_x;
    logic signed [DELTA_W-1:0] diff_y;
    logic signed [DELTA_W-1:0] abs_x;
    logic signed [DELTA_W-1:0] abs_y;
    logic signed [ERR_W:0]     e2;
    logic signed [ERR_W:0]     dx_ext;
    logic signed [ERR_W:0]     dy_ext;
    logic signed [ERR_W-1:0]   dx_err;
    logic signed [ERR_W-1:0]   dy_err;
    logic                      move_x;
    logic                      move_y;
    logic                      done;
    logic                      cut;

    assign diff_x = DELTA_W'(xe_reg) - DELTA_W'(x_reg);
    assign diff_y = DELTA_W'(ye_reg) - DELTA_W'(y_reg);
    assign abs_x  = diff_x[DELTA_W-1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[DELTA_W-1] ? -diff_y : diff_y;

    assign dx_err = $signed(ERR_W'(dx_reg));
    assign dy_err = $signed(ERR_W'(dy_reg));
    assign dx_ext = $signed((ERR_W + 1)'(dx_reg));
    assign dy_ext = $signed((ERR_W + 1)'(dy_reg));
    assign e2     = $signed({err_reg, 1'b0});
    assign move_x = e2 > -dy_ext;
    assign move_y = e2 < dx_ext;

    assign done = (x_reg == xe_reg) && (y_reg == ye_reg);
    assign cut  = !done && (cnt_reg == CNT_W'(MAX_POINTS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LR_IDLE:
            begin
                if (start)
                begin
                    state_next = LR_SETUP;
                end
            end
            LR_SETUP:
            begin
                state_next = LR_WALK;
            end
            LR_WALK:
            begin
                if (advance && (done || cut))
                begin
                    state_next = LR_IDLE;
                end
            end
            default:
            begin
                state_next = LR_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle        = 1'b0;
        point_valid = 1'b0;
        case (state_reg)
            LR_IDLE:  idle        = 1'b1;
            LR_WALK:  point_valid = 1'b1;
            default:  ;
        endcase
        point = '{x: x_reg, y: y_reg, last: done || cut, trunc: cut};
    end

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        xe_next     = xe_reg;
        ye_next     = ye_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            LR_IDLE:
            begin
                if (start)
                begin
                    x_next  = seg_in.start_x;
                    y_next  = seg_in.start_y;
                    xe_next = seg_in.end_x;
                    ye_next = seg_in.end_y;
                end
            end
            LR_SETUP:
            begin
                dx_next     = abs_x;
                dy_next     = abs_y;
                sx_neg_next = !(x_reg < xe_reg);
                sy_neg_next = !(y_reg < ye_reg);
                err_next    = $signed(ERR_W'(abs_x)) - $signed(ERR_W'(abs_y));
                cnt_next    = '0;
            end
            LR_WALK:
            begin
                // step toward the end point once the current point is taken
                if (advance)
                begin
                    err_next = err_reg - (move_x ? dy_err : '0) + (move_y ? dx_err : '0);
                    if (move_x)
                    begin
                        x_next = sx_neg_reg ? x_reg - COORD_W'(1) : x_reg + COORD_W'(1);
                    end
                    if (move_y)
                    begin
                        y_next = sy_neg_reg ? y_reg - COORD_W'(1) : y_reg + COORD_W'(1);
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        xe_reg     <= xe_next;
        ye_reg     <= ye_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
    end

endmodule

/* rtl/core/line_rasterizer_top.sv */
// Channel  Modport  Request
// seg      sink     start_x, start_y, end_x, end_y
// pts      source   point_x, point_y, write_address, write_enable,
//                   pixel_color, last_point, truncated
// cfg      sink     index, data (always ready)
//
// The idle state takes the request, a setup state computes the deltas and error
// term, then the walker gives one point per cycle through the output register
// while pts is ready. A segment has at most MAX_POINTS points. Reset clears the
// walker, the output valid and the canvas registers to defaults. A stall on pts
// holds the walker on its current point.
`include "line_rasterizer_top_assert.svh"

module line_rasterizer_top import lr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    lr_seg_if.sink   seg,
    lr_pt_if.source  pts,
    lr_cfg_if.sink   cfg
);

    logic [DIM_W-1:0]          width_reg, width_next;
    logic [DIM_W-1:0]          height_reg, height_next;
    logic [COLOR_W-1:0]        color_reg, color_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic [ADDR_W-1:0]         out_addr_reg;
    logic                      out_we_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic                      out_last_reg;
    logic                      out_trunc_reg;

    lr_seg_t                   seg_in;
    lr_point_t                 point;
    logic                      walk_idle;
    logic                      point_valid;
    logic                      advance;
    logic                      in_canvas;
    logic [2*DIM_W-1:0]        row_base;
    logic [2*DIM_W-1:0]        addr_sum;

    assign seg_in = '{start_x: seg.start_x, start_y: seg.start_y,
                      end_x: seg.end_x, end_y: seg.end_y};
    assign seg.ready = walk_idle;
    assign cfg.ready = 1'b1;

    assign advance = point_valid && (!out_valid_reg || pts.ready);

    lr_walk u_walk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (seg.valid && walk_idle),
        .seg_in      (seg_in),
        .advance     (advance),
        .idle        (walk_idle),
        .point_valid (point_valid),
        .point       (point)
    );

    assign in_canvas = !point.x[COORD_W-1] && (point.x[DIM_W-1:0] < width_reg) &&
                       !point.y[COORD_W-1] && (point.y[DIM_W-1:0] < height_reg);
    assign row_base = point.y[DIM_W-1:0] * width_reg;
    assign addr_sum = row_base + (2*DIM_W)'(point.x[DIM_W-1:0]);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        color_next  = color_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_CANVAS_WIDTH:  width_next  = clamp_dim(cfg.data[DIM_W-1:0], MAX_WIDTH);
                REG_CANVAS_HEIGHT: height_next = clamp_dim(cfg.data[DIM_W-1:0], MAX_HEIGHT);
                REG_DRAW_COLOR:    color_next  = cfg.data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (pts.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_x_reg     <= point.x;
            out_y_reg     <= point.y;
            out_addr_reg  <= in_canvas ? addr_sum[ADDR_W-1:0] : '0;
            out_we_reg    <= in_canvas;
            out_color_reg <= color_reg;
            out_last_reg  <= point.last;
            out_trunc_reg <= point.trunc;
        end
    end

    assign pts.valid         = out_valid_reg;
    assign pts.point_x       = out_x_reg;
    assign pts.point_y       = out_y_reg;
    assign pts.write_address = out_addr_reg;
    assign pts.write_enable  = out_we_reg;
    assign pts.pixel_color   = out_color_reg;
    assign pts.last_point    = out_last_reg;
    assign pts.truncated     = out_trunc_reg;

    `LR_ASSERT_NEXT(a_one_segment, seg.valid && seg.ready, !seg.ready, "segment taken while busy")
    `LR_ASSERT_NOW(a_trunc_last, pts.valid && pts.truncated, pts.last_point, "truncated not last")
    `LR_ASSERT_NOW(a_clip_addr, pts.valid && !pts.write_enable, pts.write_address == '0, "clip addr")

endmodule

/* tb/line_rasterizer_top_test.sv */
module line_rasterizer_top_test;
    import lr_pkg::*;

    localparam int          RANDOM_ITEMS  = 470;
    localparam int          PHASES        = 8;
    localparam int          SETTLE_CYCLES = MAX_POINTS + 8;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [ADDR_W-1:0]         addr;
        logic                      enable;
        logic [COLOR_W-1:0]        color;
        logic                      last;
        logic                      trunc;
    } raster_point_t;

    logic clk = 1'b0;
    logic rst_n;

    lr_seg_if seg_ch();
    lr_pt_if  pts_ch();
    lr_cfg_if cfg_ch();

    line_rasterizer_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_ch),
        .pts   (pts_ch),
        .cfg   (cfg_ch)
    );

    logic [DIM_W-1:0]   canvas_w   = WIDTH_RESET;
    logic [DIM_W-1:0]   canvas_h   = HEIGHT_RESET;
    logic [COLOR_W-1:0] paint_color = '0;

    raster_point_t pending_points[$];
    int            mismatches  = 0;
    int            seg_calm    = 0;
    int            pts_calm    = 0;
    int unsigned   cycle_count = 0;

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic signed [COORD_W-1:0] to_coord(input int v);
        if (v < -2048)
            v = -2048;
        if (v > 2047)
            v = 2047;
        return COORD_W'(v);
    endfunction

    function automatic void rasterize_segment(input logic signed [COORD_W-1:0] x0, y0, x1, y1);
        int            x, y, xe, ye, dx, dy, step_x, step_y, err, e2, span_w, span_h, count;
        bit            done, cut, in_canvas;
        raster_point_t p;
        x      = x0;
        y      = y0;
        xe     = x1;
        ye     = y1;
        span_w = (canvas_w < MAX_WIDTH) ? int'(canvas_w) : MAX_WIDTH;
        span_h = (canvas_h < MAX_HEIGHT) ? int'(canvas_h) : MAX_HEIGHT;
        dx     = (xe > x) ? xe - x : x - xe;
        dy     = (ye > y) ? ye - y : y - ye;
        step_x = (x < xe) ? 1 : -1;
        step_y = (y < ye) ? 1 : -1;
        err    = dx - dy;
        count  = 0;
        done   = 1'b0;
        cut    = 1'b0;
        while (!(done || cut))
        begin
            done      = (x == xe) && (y == ye);
            cut       = !done && (count + 1 >= MAX_POINTS);
            in_canvas = (x >= 0) && (x < span_w) && (y >= 0) && (y < span_h);
            p.x      = COORD_W'(x);
            p.y      = COORD_W'(y);
            p.addr   = in_canvas ? ADDR_W'(y * span_w + x) : '0;
            p.enable = in_canvas;
            p.color  = paint_color;
            p.last   = done || cut;
            p.trunc  = cut;
            pending_points = {pending_points, p};
            count++;
            if (!(done || cut))
            begin
                e2 = 2 * err;
                if (e2 > -dy)
                begin
                    err -= dy;
                    x   += step_x;
                end
                if (e2 < dx)
                begin
                    err += dx;
                    y   += step_y;
                end
            end
        end
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want, got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_segment(input logic signed [COORD_W-1:0] x0, y0, x1, y1);
        int gap;
        gap = draw_gap(seg_calm);
        if (gap > 0)
        begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.valid   <= 1'b1;
        seg_ch.start_x <= x0;
        seg_ch.start_y <= y0;
        seg_ch.end_x   <= x1;
        seg_ch.end_y   <= y1;
        do @(posedge clk); while (!seg_ch.ready);
        rasterize_segment(x0, y0, x1, y1);
    endtask

    task automatic drain_points();
        seg_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (index)
            REG_CANVAS_WIDTH:  canvas_w    = data[DIM_W-1:0];
            REG_CANVAS_HEIGHT: canvas_h    = data[DIM_W-1:0];
            REG_DRAW_COLOR:    paint_color = data;
            default:           ;
        endcase
    endtask

    // upper data bits are junk; the block keeps only the register width
    task automatic program_canvas(input logic [DIM_W-1:0] width, height,
                                  input logic [COLOR_W-1:0] color);
        drain_points();
        write_register(REG_CANVAS_WIDTH, (CFG_DATA_W'($urandom) << DIM_W) | CFG_DATA_W'(width));
        write_register(REG_SPARE, CFG_DATA_W'($urandom));
        write_register(REG_CANVAS_HEIGHT, (CFG_DATA_W'($urandom) << DIM_W) | CFG_DATA_W'(height));
        write_register(REG_DRAW_COLOR, color);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_segment();
        int span_w, span_h, reach, x0, y0, x1, y1, kind;
        int rim[7];
        rim    = '{-2048, -2047, -1, 0, 1, 2046, 2047};
        span_w = (canvas_w < MAX_WIDTH) ? int'(canvas_w) : MAX_WIDTH;
        span_h = (canvas_h < MAX_HEIGHT) ? int'(canvas_h) : MAX_HEIGHT;
        kind   = $urandom_range(0, 9);
        if (kind == 8)
        begin
            send_segment(COORD_W'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom));
        end
        else if (kind == 9)
        begin
            send_segment(to_coord(rim[$urandom_range(0, 6)]), to_coord(rim[$urandom_range(0, 6)]),
                         to_coord(rim[$urandom_range(0, 6)]), to_coord(rim[$urandom_range(0, 6)]));
        end
        else
        begin
            reach = (kind < 6) ? 8 : 40;
            x0    = int'($urandom_range(0, span_w + 16)) - 8;
            y0    = int'($urandom_range(0, span_h + 16)) - 8;
            x1    = x0 + int'($urandom_range(0, 2 * reach)) - reach;
            y1    = y0 + int'($urandom_range(0, 2 * reach)) - reach;
            send_segment(to_coord(x0), to_coord(y0), to_coord(x1), to_coord(y1));
        end
    endtask

    task automatic test_reset_defaults();
        send_segment(0, 0, 0, 0);
        send_segment(1023, 1023, 1023, 1023);
        send_segment(1024, 1024, 1022, 1022);
    endtask

    task automatic test_directed_segments();
        send_segment(1024, 0, 1020, 0);
        send_segment(5, -3, 5, 3);
        send_segment(0, 0, 63, 0);
        send_segment(0, 0, 64, 0);
        send_segment(-2048, -2048, 2047, 2047);
        send_segment(2047, 2047, -2048, -2048);
        send_segment(-2048, 2047, 2047, -2048);
        send_segment(10, 10, 13, 20);
        send_segment(20, 10, 3, 7);
        send_segment(-5, -5, -5, -5);
        send_segment(3, 0, 0, 3);
        send_segment(0, 70, 0, 0);
    endtask

    task automatic test_canvas_limits();
        program_canvas(11'd2047, 11'd2047, 32'hFFFF_FFFF);
        send_segment(1020, 0, 1030, 3);
        send_segment(1000, 1020, 1000, 1030);
        program_canvas(11'd0, 11'd5, 32'h0);
        send_segment(0, 0, 3, 3);
        program_canvas(11'd1, 11'd1, 32'hA5C3_0F96);
        send_segment(-1, -1, 1, 1);
        program_canvas(11'd1024, 11'd0, 32'h5A3C_F069);
        send_segment(0, 0, 2, 0);
    endtask

    task automatic test_random_segments();
        int phase_w[PHASES];
        int phase_h[PHASES];
        phase_w = '{1024, 2047, 0, 1, 1, 64, 1, 1024};
        phase_h = '{1024, 2047, 1024, 1, 1, 48, 1, 0};
        phase_w[4] = $urandom_range(1, 1024);
        phase_h[4] = $urandom_range(1, 1024);
        phase_w[6] = $urandom_range(0, 2047);
        phase_h[6] = $urandom_range(0, 2047);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            program_canvas(DIM_W'(phase_w[ph]), DIM_W'(phase_h[ph]),
                           (ph == 0) ? 32'hFFFF_FFFF : (ph == 3) ? 32'h0 : 32'($urandom));
            repeat (RANDOM_ITEMS / PHASES + 1) send_random_segment();
        end
    endtask

    initial
    begin : point_monitor
        raster_point_t want;
        int            stall;
        pts_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(pts_calm);
            if (stall > 0)
            begin
                pts_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pts_ch.ready <= 1'b1;
            do @(posedge clk); while (pts_ch.valid !== 1'b1);
            if (pending_points.size() == 0)
            begin
                $error("point (%0d, %0d) with no request outstanding",
                       pts_ch.point_x, pts_ch.point_y);
                mismatches++;
            end
            else
            begin
                want = pending_points.pop_front();
                check_field("point_x", want.x, pts_ch.point_x);
                check_field("point_y", want.y, pts_ch.point_y);
                check_field("write_address", want.addr, pts_ch.write_address);
                check_field("write_enable", want.enable, pts_ch.write_enable);
                check_field("pixel_color", want.color, pts_ch.pixel_color);
                check_field("last_point", want.last, pts_ch.last_point);
                check_field("truncated", want.trunc, pts_ch.truncated);
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        seg_ch.valid   = 1'b0;
        seg_ch.start_x = '0;
        seg_ch.start_y = '0;
        seg_ch.end_x   = '0;
        seg_ch.end_y   = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed_segments();
        test_canvas_limits();
        test_random_segments();

        drain_points();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lr_pkg.sv
rtl/core/lr_if.sv
rtl/core/lr_walk.sv
rtl/core/line_rasterizer_top.sv
tb/line_rasterizer_top_test.sv
